>>> rtl/fpr_pkg.sv
// shared types and constants for the floating-point remainder unit
`default_nettype none
package fpr_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INV   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [63:0] QNAN_D  = 64'h7FF8000000000000;
    localparam logic [63:0] QNAN_S  = 64'h0000_0000_7FC00000;

    typedef enum logic [2:0] {
        S_IDLE, S_NORMA, S_NORMB, S_REDUCE, S_RENORM, S_PACK, S_OUT
    } t_state;

    // control from sequencer to datapath
    typedef struct packed {
        logic load;
        logic norm_a;
        logic norm_b;
        logic reduce;
        logic renorm;
    } t_ctl;

    // status from datapath to sequencer
    typedef struct packed {
        logic a_norm_done;
        logic b_norm_done;
        logic red_last;
        logic red_exact;
        logic ren_done;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/fpr_datapath.sv
// significand registers and the shared subtract/shift unit
`default_nettype none
module fpr_datapath import fpr_pkg::*; (
    input  wire         i_clk,
    input  wire  t_ctl  i_ctl,
    input  wire         i_dbl,
    input  wire  [63:0] i_a,
    input  wire  [63:0] i_b,
    output t_sts        o_sts,
    output logic [63:0] o_mag
);
    logic [53:0] r_mx, r_my, n_mx, n_my;
    logic signed [12:0] r_ex, r_ey, n_ex, n_ey;
    logic [53:0] hid, diff;
    logic        ge;
    logic [5:0]  mb;
    logic [10:0] ea, eb;
    logic [12:0] sh;

    assign mb   = i_dbl ? 6'd52 : 6'd23;
    assign hid  = 54'd1 << mb;
    assign ea   = i_dbl ? i_a[62:52] : {3'd0, i_a[30:23]};
    assign eb   = i_dbl ? i_b[62:52] : {3'd0, i_b[30:23]};
    // one shared compare and subtract
    assign ge   = r_mx >= r_my;
    assign diff = r_mx - r_my;

    assign o_sts.a_norm_done = r_mx >= hid;
    assign o_sts.b_norm_done = r_my >= hid;
    assign o_sts.red_last    = !(r_ex > r_ey);
    assign o_sts.red_exact   = r_mx == r_my;
    assign o_sts.ren_done    = r_mx >= hid;

    always_comb begin
        n_mx = r_mx;
        n_my = r_my;
        n_ex = r_ex;
        n_ey = r_ey;
        if (i_ctl.load) begin
            n_mx = {2'd0, (i_dbl ? i_a[51:0] : {29'd0, i_a[22:0]})};
            n_my = {2'd0, (i_dbl ? i_b[51:0] : {29'd0, i_b[22:0]})};
            if (ea == 11'd0) n_ex = 13'sd1;
            else begin
                n_ex = $signed({2'b0, ea});
                n_mx = n_mx | hid;
            end
            if (eb == 11'd0) n_ey = 13'sd1;
            else begin
                n_ey = $signed({2'b0, eb});
                n_my = n_my | hid;
            end
        end else if (i_ctl.norm_a) begin
            n_mx = r_mx << 1;
            n_ex = r_ex - 13'sd1;
        end else if (i_ctl.norm_b) begin
            n_my = r_my << 1;
            n_ey = r_ey - 13'sd1;
        end else if (i_ctl.reduce) begin
            n_mx = ge ? diff : r_mx;
            if (r_ex > r_ey) begin
                n_mx = n_mx << 1;
                n_ex = r_ex - 13'sd1;
            end
        end else if (i_ctl.renorm) begin
            n_mx = r_mx << 1;
            n_ex = r_ex - 13'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx <= n_mx;
        r_my <= n_my;
        r_ex <= n_ex;
        r_ey <= n_ey;
    end

    // pack: normal or subnormal result
    always_comb begin
        sh = 13'd1 - 13'(r_ex);
        if (r_ex > 13'sd0) begin
            o_mag = 64'(r_mx - hid) | (64'(r_ex) << mb);
        end else if (sh >= 13'd54) begin
            o_mag = 64'd0;
        end else begin
            o_mag = 64'(r_mx >> sh[5:0]);
        end
    end
endmodule
`default_nettype wire

>>> rtl/fp_remainder_unit.sv
// top level of the truncated floating-point remainder unit
// usage:
//   cfg channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes float_mode;
//     0 strict (faults give status), 1 ieee (faults give quiet nan)
//   input stream s_axis: tdata holds is_double, dividend, divisor from bit 0 up
//   output stream m_axis: tdata holds remainder, status from bit 0 up
// path from the input transfer to the result, decided in the pack state:
//   special operands and |a| <= |b|: result goes straight to the output state
//   otherwise: subnormal normalization shifts of a and b (up to 52 each),
//   then one reduction step per unit of exponent difference (up to about
//   2100 for binary64), then result renormalization shifts (up to 52), all
//   on the single shared compare/subtract/shift unit that does one step a
//   cycle; a reduction that comes out exact finishes early
// after each result transfer the block returns to idle before it accepts
// another item
// one item at a time: s_axis_tready is low from acceptance until the
// result transfer completes; a stalled receiver holds the result and the
// block with it
// reset (synchronous, active low) returns to idle, float_mode to strict
`default_nettype none
module fp_remainder_unit import fpr_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [135:0] s_axis_tdata,  // is_double, dividend, divisor, zero fill
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [71:0]  m_axis_tdata   // remainder, status, zero fill
);
    t_state r_state, n_state;
    logic r_mode;
    logic r_dbl;
    logic [63:0] r_a, r_b, r_res, n_res;
    logic [1:0] r_stat, n_stat;
    t_ctl ctl;
    t_sts sts;
    logic [63:0] mag_out;

    logic [63:0] a, b, wm, fm, mag, sbit, sx;
    logic [5:0] mb;
    logic [10:0] ea, eb, emax;
    logic a_top, b_top, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, inv, div0;

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_stat, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
    end

    // classification from captured operands
    assign wm   = r_dbl ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    assign a    = r_a & wm;
    assign b    = r_b & wm;
    assign mb   = r_dbl ? 6'd52 : 6'd23;
    assign fm   = r_dbl ? 64'h000fffffffffffff : 64'h00000000007fffff;
    assign sbit = r_dbl ? 64'h8000000000000000 : 64'h0000000080000000;
    assign mag  = sbit - 64'd1;
    assign sx   = a & sbit;
    assign emax = r_dbl ? 11'h7ff : 11'h0ff;
    assign ea   = 11'((a >> mb)) & emax;
    assign eb   = 11'((b >> mb)) & emax;
    assign a_top  = ea == emax;
    assign b_top  = eb == emax;
    assign a_nan  = a_top && ((a & fm) != 0);
    assign b_nan  = b_top && ((b & fm) != 0);
    assign a_inf  = a_top && ((a & fm) == 0);
    assign b_inf  = b_top && ((b & fm) == 0);
    assign a_zero = (a & mag) == 0;
    assign b_zero = (b & mag) == 0;
    assign inv    = a_nan || b_nan || a_inf || (a_zero && b_zero);
    assign div0   = !a_top && !a_zero && b_zero;

    fpr_datapath u_dp (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_dbl (r_dbl),
        .i_a   (a),
        .i_b   (b),
        .o_sts (sts),
        .o_mag (mag_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (s_axis_tvalid && s_axis_tready) begin
            r_dbl <= s_axis_tdata[0];
            r_a   <= s_axis_tdata[64:1];
            r_b   <= s_axis_tdata[128:65];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_stat  = r_stat;
        ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_PACK;
            end
            S_PACK: begin
                // classify and load
                n_stat = ST_OK;
                n_state = S_OUT;
                if (inv || div0) begin
                    if (r_mode) n_res = r_dbl ? QNAN_D : QNAN_S;
                    else begin
                        n_res  = 64'd0;
                        n_stat = inv ? ST_INV : ST_DIV0;
                    end
                end else if (b_inf) begin
                    n_res = a;
                end else if ((a & mag) == (b & mag)) begin
                    n_res = sx;
                end else if ((a & mag) < (b & mag)) begin
                    n_res = a;
                end else begin
                    ctl.load = 1'b1;
                    n_state  = S_NORMA;
                end
            end
            S_NORMA: begin
                if (sts.a_norm_done) n_state = S_NORMB;
                else ctl.norm_a = 1'b1;
            end
            S_NORMB: begin
                if (sts.b_norm_done) n_state = S_REDUCE;
                else ctl.norm_b = 1'b1;
            end
            S_REDUCE: begin
                if (sts.red_exact) begin
                    n_res   = sx;
                    n_state = S_OUT;
                end else begin
                    ctl.reduce = 1'b1;
                    if (sts.red_last) n_state = S_RENORM;
                end
            end
            S_RENORM: begin
                if (sts.ren_done) begin
                    n_res   = (mag_out | sx) & wm;
                    n_state = S_OUT;
                end else ctl.renorm = 1'b1;
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> bench/testbench.sv
// testbench for the truncated floating-point remainder unit
module testbench;
    import fpr_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    typedef struct packed {
        logic        is_double;
        logic [63:0] lhs;
        logic [63:0] rhs;
    } t_rem_op;

    typedef struct packed {
        logic [63:0] bits;
        logic [1:0]  status;
    } t_rem_res;

    t_rem_op  op_queue[$];
    t_rem_res rem_expected[$];
    logic     mode_now = 1'b0;
    int       n_errors = 0;
    int       cycle_count = 0;
    int       hold_cycles = 0;
    int       gap_cycles = 0;
    bit       stim_done = 1'b0;
    bit       sent_one = 1'b0;

    fp_remainder_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // exact truncated remainder of two sign-magnitude floats
    function automatic logic [63:0] trunc_rem(logic [63:0] ax, logic [63:0] ay, bit dbl);
        int mb, ex, ey, sh;
        logic [63:0] hid, fmask, sbit, mag, sx, mx, my, emask;
        mb = dbl ? 52 : 23;
        emask = dbl ? 64'h7ff : 64'hff;
        hid = 64'd1 << mb;
        fmask = hid - 1;
        sbit = dbl ? 64'h8000000000000000 : 64'h80000000;
        mag = sbit - 1;
        sx = ax & sbit;
        ex = int'((ax >> mb) & emask);
        ey = int'((ay >> mb) & emask);
        if ((ax & mag) == (ay & mag)) return sx;
        if ((ax & mag) < (ay & mag)) return ax;
        mx = ax & fmask;
        my = ay & fmask;
        if (ex == 0) begin
            ex = 1;
            while (mx < hid) begin mx = mx << 1; ex--; end
        end else begin
            mx = mx | hid;
        end
        if (ey == 0) begin
            ey = 1;
            while (my < hid) begin my = my << 1; ey--; end
        end else begin
            my = my | hid;
        end
        for (; ex > ey; ex--) begin
            if (mx >= my) begin
                if (mx == my) return sx;
                mx = mx - my;
            end
            mx = mx << 1;
        end
        if (mx >= my) begin
            if (mx == my) return sx;
            mx = mx - my;
        end
        while (mx < hid) begin mx = mx << 1; ex--; end
        if (ex > 0) begin
            mx = (mx - hid) | (64'(ex) << mb);
        end else begin
            sh = 1 - ex;
            mx = (sh >= 64) ? 64'd0 : (mx >> sh);
        end
        return mx | sx;
    endfunction

    function automatic t_rem_res predict_rem(t_rem_op op, logic mode);
        t_rem_res r;
        logic [63:0] a, b, wmask, fmask, mag, emask;
        int mb;
        bit a_top, b_top, a_zero, b_zero, invalid, div0;
        mb = op.is_double ? 52 : 23;
        emask = op.is_double ? 64'h7ff : 64'hff;
        wmask = op.is_double ? '1 : 64'hffffffff;
        a = op.lhs & wmask;
        b = op.rhs & wmask;
        fmask = (64'd1 << mb) - 1;
        mag = op.is_double ? 64'h7fffffffffffffff : 64'h7fffffff;
        a_top = ((a >> mb) & emask) == emask;
        b_top = ((b >> mb) & emask) == emask;
        a_zero = (a & mag) == 0;
        b_zero = (b & mag) == 0;
        invalid = a_top || (b_top && (b & fmask) != 0) || (a_zero && b_zero);
        div0 = !a_top && !a_zero && b_zero;
        r.status = ST_OK;
        if (invalid || div0) begin
            if (mode) begin
                r.bits = op.is_double ? QNAN_D : QNAN_S;
            end else begin
                r.bits = '0;
                r.status = invalid ? ST_INV : ST_DIV0;
            end
        end else if (b_top) begin
            r.bits = a;
        end else begin
            r.bits = trunc_rem(a, b, op.is_double) & wmask;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // random operand: biased to specials and near exponents
    function automatic logic [63:0] rand_float(bit dbl, logic [63:0] other);
        logic [63:0] v;
        int p;
        v = {$urandom, $urandom};
        p = $urandom_range(0, 99);
        if (dbl) begin
            if (p < 8) v[62:52] = '1;
            else if (p < 16) v[62:52] = '0;
            else if (p < 22) v[62:0] = '0;
            else if (p < 70) v[62:52] = other[62:52] + 11'($urandom_range(0, 40)) - 11'd20;
        end else begin
            if (p < 8) v[30:23] = '1;
            else if (p < 16) v[30:23] = '0;
            else if (p < 22) v[30:0] = '0;
            else if (p < 70) v[30:23] = other[30:23] + 8'($urandom_range(0, 20)) - 8'd10;
        end
        return v;
    endfunction

    task automatic push_op(bit dbl, logic [63:0] a, logic [63:0] b);
        t_rem_op op;
        op.is_double = dbl;
        op.lhs = a;
        op.rhs = b;
        op_queue.push_back(op);
    endtask

    task automatic write_mode(logic m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_now = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (op_queue.size() != 0 || s_axis_tvalid || rem_expected.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic directed_ops(bit dbl);
        logic [63:0] one, inf, nan, tiny, maxf, sgn;
        one = dbl ? 64'h3ff0000000000000 : 64'h3f800000;
        inf = dbl ? 64'h7ff0000000000000 : 64'h7f800000;
        nan = dbl ? 64'h7ff0000000000001 : 64'h7fc00001;
        tiny = 64'd1;
        maxf = dbl ? 64'h7fefffffffffffff : 64'h7f7fffff;
        sgn = dbl ? 64'h8000000000000000 : 64'h80000000;
        push_op(dbl, nan, one);
        push_op(dbl, one, nan);
        push_op(dbl, inf | sgn, one);
        push_op(dbl, 64'd0, sgn);
        push_op(dbl, one, 64'd0);
        push_op(dbl, one | sgn, inf);
        push_op(dbl, tiny, one);
        push_op(dbl, one | sgn, one);
        push_op(dbl, maxf, tiny);
        push_op(dbl, maxf | sgn, 64'h3);
        push_op(dbl, dbl ? 64'h4014000000000000 : 64'h40a00000, one | sgn);
        push_op(dbl, {32'hffffffff, one[31:0]} | one, 64'hffffffff00000000 | 64'h3);
    endtask

    // driver: presents items from the pending queue
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && sent_one) begin
                sent_one <= 1'b0;
            end
            if (!s_axis_tvalid || sent_one) begin
                if (gap_cycles > 0) begin
                    gap_cycles <= gap_cycles - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    s_axis_tdata <= {7'd0, op_queue[0].rhs, op_queue[0].lhs,
                                     op_queue[0].is_double};
                    s_axis_tvalid <= 1'b1;
                    void'(op_queue.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random ready, long hold counted down here
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (rand_gap() == 0);
            end
        end
    end

    // monitor: accepted input transfers feed the predictor, results are checked
    always @(posedge i_clk) begin
        t_rem_op op;
        t_rem_res want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            op.is_double = s_axis_tdata[0];
            op.lhs = s_axis_tdata[64:1];
            op.rhs = s_axis_tdata[128:65];
            rem_expected.push_back(predict_rem(op, mode_now));
            sent_one <= 1'b1;
            gap_cycles <= rand_gap();
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rem_expected.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = rem_expected.pop_front();
                if (m_axis_tdata[63:0] !== want.bits)
                    report_mismatch("remainder", m_axis_tdata[63:0], want.bits);
                if (m_axis_tdata[65:64] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[65:64]), 64'(want.status));
            end
        end
        if (cycle_count > 4000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        bit dbl;
        logic [63:0] a;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // strict mode is the reset value
        directed_ops(1'b0);
        directed_ops(1'b1);
        wait_drained();
        write_mode(1'b1);
        directed_ops(1'b0);
        push_op(1'b1, 64'h7ff8000000000000, 64'd0);
        hold_cycles = 300;
        wait_drained();
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            for (k = 0; k < 64; k++) begin
                dbl = $urandom_range(0, 1);
                a = {$urandom, $urandom};
                // mostly small exponent spread to keep the run short
                push_op(dbl, a, rand_float(dbl, a));
            end
            if (phase == 2) hold_cycles = 400;
            wait_drained();
        end
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && rem_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/fpr_pkg.sv
rtl/fpr_datapath.sv
rtl/fp_remainder_unit.sv
bench/testbench.sv
